### src/hysteresis_peak_trough_detector_assert.svh
// assertion macros for the hysteresis peak and trough detector
`ifndef HYSTERESIS_PEAK_TROUGH_DETECTOR_ASSERT_SVH
`define HYSTERESIS_PEAK_TROUGH_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define HPTD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hptd assertion failed");
// next-cycle implication, checked out of reset
`define HPTD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hptd assertion failed");
`else
`define HPTD_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define HPTD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### src/hptd_pkg.sv
// shared types, constants and helpers of the peak and trough detector
`timescale 1ns / 1ps

package hptd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int DELTA_BITS  = 16;
  localparam int IDX_BITS    = 12;
  localparam int CNT_BITS    = 13;
  localparam int CMP_BITS    = 18;

  localparam logic [IDX_BITS-1:0]   IDX_MAX     = 12'd4095;
  localparam logic [CNT_BITS-1:0]   CNT_MAX     = 13'd8191;
  localparam logic [DELTA_BITS-1:0] DELTA_RESET = 16'd200;

  localparam logic EVT_PEAK   = 1'b0;
  localparam logic EVT_TROUGH = 1'b1;

  // direction of travel, one-hot
  typedef enum logic [2:0] {
    DIR_UNDEC = 3'b001,
    DIR_RISE  = 3'b010,
    DIR_FALL  = 3'b100
  } dir_t;

  // detector state carried between samples
  typedef struct packed {
    dir_t                          dir;
    logic signed [SAMPLE_BITS-1:0] max_value;
    logic [IDX_BITS-1:0]           max_index;
    logic signed [SAMPLE_BITS-1:0] min_value;
    logic [IDX_BITS-1:0]           min_index;
    logic [IDX_BITS-1:0]           sample_index;
    logic [CNT_BITS-1:0]           peak_count;
    logic [CNT_BITS-1:0]           trough_count;
  } state_t;

  // one reported extreme
  typedef struct packed {
    logic                          kind;
    logic [IDX_BITS-1:0]           index;
    logic signed [SAMPLE_BITS-1:0] value;
    logic [CNT_BITS-1:0]           number;
  } event_t;

  // state at reset and at the start of every window
  function automatic state_t clear_state();
    state_t s;
    s              = '0;
    s.dir          = DIR_UNDEC;
    return s;
  endfunction

endpackage

### src/hptd_ifs.sv
// request channels of the peak and trough detector
`timescale 1ns / 1ps

// sample requests
interface hptd_sample_if;
  import hptd_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_sample;
  modport source (output valid, sample, last_sample, input ready);
  modport sink (input valid, sample, last_sample, output ready);
endinterface

// event requests
interface hptd_event_if;
  import hptd_pkg::*;
  logic                          valid;
  logic                          ready;
  logic                          event_kind;
  logic [IDX_BITS-1:0]           event_index;
  logic signed [SAMPLE_BITS-1:0] event_value;
  logic [CNT_BITS-1:0]           event_number;
  modport source (output valid, event_kind, event_index, event_value, event_number,
                  input ready);
  modport sink (input valid, event_kind, event_index, event_value, event_number,
                output ready);
endinterface

// delta register writes
interface hptd_cfg_if;
  import hptd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [DELTA_BITS-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### src/hptd_core.sv
// next-state and event logic for one sample
`timescale 1ns / 1ps

module hptd_core
  import hptd_pkg::*;
(
  input  state_t                        st,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic                          last,
  input  logic [DELTA_BITS-1:0]         delta,
  output state_t                        st_next,
  output logic                          emit,
  output event_t                        ev
);

  state_t                     s;
  state_t                     n;
  logic signed [CMP_BITS-1:0] xw;
  logic signed [CMP_BITS-1:0] dw;
  logic signed [CMP_BITS-1:0] maxw;
  logic signed [CMP_BITS-1:0] minw;
  logic                       max_le_x;
  logic                       x_le_min;
  logic                       drop_hit;
  logic                       rise_hit;

  // first sample of a window seeds both extremes
  always_comb begin
    s = st;
    if (st.sample_index == '0) begin
      s.max_value = x;
      s.min_value = x;
      s.max_index = '0;
      s.min_index = '0;
    end
  end

  // exact compares at widened precision
  assign xw       = CMP_BITS'(x);
  assign dw       = $signed({2'b00, delta});
  assign maxw     = CMP_BITS'(s.max_value);
  assign minw     = CMP_BITS'(s.min_value);
  assign max_le_x = (maxw <= xw);
  assign x_le_min = (xw <= minw);
  assign drop_hit = (maxw >= xw + dw);
  assign rise_hit = (xw >= minw + dw);

  // direction rules
  always_comb begin
    n    = s;
    emit = 1'b0;
    ev   = '0;
    case (s.dir)
      DIR_UNDEC: begin
        if (drop_hit) begin
          n.dir = DIR_FALL;
        end else if (rise_hit) begin
          n.dir = DIR_RISE;
        end
        if (max_le_x) begin
          n.max_value = x;
          n.max_index = s.sample_index;
        end else if (x_le_min) begin
          n.min_value = x;
          n.min_index = s.sample_index;
        end
      end
      DIR_RISE: begin
        if (max_le_x) begin
          n.max_value = x;
          n.max_index = s.sample_index;
        end else if (drop_hit) begin
          if (s.peak_count < CNT_MAX) begin
            n.peak_count = s.peak_count + 1'b1;
          end
          emit        = 1'b1;
          ev.kind     = EVT_PEAK;
          ev.index    = s.max_index;
          ev.value    = s.max_value;
          ev.number   = n.peak_count;
          n.min_value = x;
          n.min_index = s.sample_index;
          n.dir       = DIR_FALL;
        end
      end
      default: begin
        // falling, and any unexpected code
        if (x_le_min) begin
          n.min_value = x;
          n.min_index = s.sample_index;
        end else if (rise_hit) begin
          if (s.trough_count < CNT_MAX) begin
            n.trough_count = s.trough_count + 1'b1;
          end
          emit        = 1'b1;
          ev.kind     = EVT_TROUGH;
          ev.index    = s.min_index;
          ev.value    = s.min_value;
          ev.number   = n.trough_count;
          n.max_value = x;
          n.max_index = s.sample_index;
          n.dir       = DIR_RISE;
        end
      end
    endcase
    // saturating window index
    if (s.sample_index < IDX_MAX) begin
      n.sample_index = s.sample_index + 1'b1;
    end
  end

  // end of window clears everything
  assign st_next = last ? clear_state() : n;

endmodule

### src/hysteresis_peak_trough_detector.sv
// top level of the hysteresis peak and trough detector
`timescale 1ns / 1ps
`include "hysteresis_peak_trough_detector_assert.svh"

// Usage:
//   samples : sample requests (sample, last_sample) under valid/ready.
//   events  : event requests (event_kind, event_index, event_value,
//             event_number) under valid/ready, at most one per sample.
//   cfg     : writes the 16-bit delta; always ready, write while idle.
// A sample is taken into an input register, then the compare and update
// logic runs as that register advances, loading the detector state and
// the output register, which holds the event. One sample per cycle is
// accepted while no event is stalled; the rate is set by the single state
// update per cycle that feeds the output register.
// last_sample processes the sample and then returns the window state to
// its cleared form. Reset clears the window state, empties both
// registers and loads delta with 200.
// When the receiver stalls, the pending event holds and the input
// register keeps one more sample; samples then wait until the event is
// taken.
module hysteresis_peak_trough_detector
  import hptd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  hptd_sample_if.sink  samples,
  hptd_event_if.source events,
  hptd_cfg_if.sink     cfg
);

  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic                          s1_last;
  state_t                        st;
  state_t                        st_next;
  logic                          out_valid;
  event_t                        out_ev;
  event_t                        ev;
  logic                          emit;
  logic [DELTA_BITS-1:0]         delta;
  logic                          out_adv;
  logic                          s1_fire;
  logic                          in_fire;

  // handshake control
  assign out_adv       = !out_valid || events.ready;
  assign s1_fire       = s1_valid && out_adv;
  assign samples.ready = !s1_valid || out_adv;
  assign in_fire       = samples.valid && samples.ready;
  assign cfg.ready     = 1'b1;

  // update logic
  hptd_core u_core (
    .st      (st),
    .x       (s1_sample),
    .last    (s1_last),
    .delta   (delta),
    .st_next (st_next),
    .emit    (emit),
    .ev      (ev)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= clear_state();
      delta     <= DELTA_RESET;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        st        <= st_next;
        out_valid <= emit;
      end else if (events.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready) begin
        delta <= cfg.data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample <= samples.sample;
      s1_last   <= samples.last_sample;
    end
    if (s1_fire && emit) begin
      out_ev <= ev;
    end
  end

  // result outputs
  assign events.valid        = out_valid;
  assign events.event_kind   = out_ev.kind;
  assign events.event_index  = out_ev.index;
  assign events.event_value  = out_ev.value;
  assign events.event_number = out_ev.number;

  // checks
  `HPTD_ASSERT_NOW(a_stall_cause, clk, rst, !samples.ready,
    s1_valid && out_valid && !events.ready)
  `HPTD_ASSERT_NEXT(a_window_clear, clk, rst, s1_fire && s1_last,
    st.sample_index == '0 && st.peak_count == '0 && st.trough_count == '0)
  `HPTD_ASSERT_NOW(a_event_dir, clk, rst, s1_fire && emit, st.dir != DIR_UNDEC)
  `HPTD_ASSERT_NOW(a_event_index, clk, rst, s1_fire && emit && st.sample_index != '0,
    ev.index <= st.sample_index && ev.number != '0)

endmodule

### sim/tb_hysteresis_peak_trough_detector.sv
// self-checking testbench for the hysteresis peak and trough detector
`timescale 1ns / 1ps

module tb_hysteresis_peak_trough_detector;
  import hptd_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_WINDOW   = 100;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 80;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          last;
  } sample_req_t;

  logic clk = 1'b0;
  logic rst;

  hptd_sample_if samples_ch ();
  hptd_event_if  events_ch ();
  hptd_cfg_if    cfg_ch ();

  hysteresis_peak_trough_detector dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .events  (events_ch),
    .cfg     (cfg_ch)
  );

  // pending sample requests and predicted events
  sample_req_t pending_samples[$];
  event_t      expected_events[$];

  // tracked detector state
  dir_t                  trk_dir;
  int                    trk_max;
  int                    trk_min;
  logic [IDX_BITS-1:0]   trk_max_idx;
  logic [IDX_BITS-1:0]   trk_min_idx;
  logic [IDX_BITS-1:0]   trk_idx;
  logic [CNT_BITS-1:0]   trk_peaks;
  logic [CNT_BITS-1:0]   trk_troughs;
  logic [DELTA_BITS-1:0] cur_delta = DELTA_RESET;

  // run statistics
  int fail_count    = 0;
  int samples_taken = 0;
  int peaks_seen    = 0;
  int troughs_seen  = 0;
  int delta_writes  = 0;

  // sender burst and receiver stall state
  int burst_left = 0;
  int gap_left   = 0;
  int stall_mode = 0;
  int mode_left  = 0;
  int stall_per  = 2;
  int stall_low  = 1;
  int stall_tick = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // window state back to its cleared form
  function automatic void clear_tracker();
    trk_dir     = DIR_UNDEC;
    trk_max     = 0;
    trk_min     = 0;
    trk_max_idx = '0;
    trk_min_idx = '0;
    trk_idx     = '0;
    trk_peaks   = '0;
    trk_troughs = '0;
  endfunction

  // advance the tracked state by one sample, queue any reported extreme
  function automatic void predict_extremes(input logic signed [SAMPLE_BITS-1:0] smp,
                                           input logic last);
    int     x;
    int     e;
    event_t ev;
    x = smp;
    e = int'(cur_delta);
    // first sample of a window loads both extremes
    if (trk_idx == '0) begin
      trk_max     = x;
      trk_min     = x;
      trk_max_idx = '0;
      trk_min_idx = '0;
    end
    case (trk_dir)
      DIR_UNDEC: begin
        if (trk_max >= x + e) trk_dir = DIR_FALL;
        else if (x >= trk_min + e) trk_dir = DIR_RISE;
        if (trk_max <= x) begin
          trk_max     = x;
          trk_max_idx = trk_idx;
        end else if (x <= trk_min) begin
          trk_min     = x;
          trk_min_idx = trk_idx;
        end
      end
      DIR_RISE: begin
        if (trk_max <= x) begin
          trk_max     = x;
          trk_max_idx = trk_idx;
        end else if (trk_max >= x + e) begin
          if (trk_peaks != CNT_MAX) trk_peaks++;
          ev.kind   = EVT_PEAK;
          ev.index  = trk_max_idx;
          ev.value  = trk_max[SAMPLE_BITS-1:0];
          ev.number = trk_peaks;
          expected_events.push_back(ev);
          trk_min     = x;
          trk_min_idx = trk_idx;
          trk_dir     = DIR_FALL;
        end
      end
      default: begin
        if (x <= trk_min) begin
          trk_min     = x;
          trk_min_idx = trk_idx;
        end else if (x >= trk_min + e) begin
          if (trk_troughs != CNT_MAX) trk_troughs++;
          ev.kind   = EVT_TROUGH;
          ev.index  = trk_min_idx;
          ev.value  = trk_min[SAMPLE_BITS-1:0];
          ev.number = trk_troughs;
          expected_events.push_back(ev);
          trk_max     = x;
          trk_max_idx = trk_idx;
          trk_dir     = DIR_RISE;
        end
      end
    endcase
    if (trk_idx != IDX_MAX) trk_idx++;
    if (last) clear_tracker();
  endfunction

  function automatic int clamp_sample(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void queue_sample(input int v, input bit last);
    sample_req_t req;
    req.smp  = v[SAMPLE_BITS-1:0];
    req.last = last;
    pending_samples.push_back(req);
  endfunction

  // windows of random walks with random content, some pure noise
  function automatic void fill_random_phase(input int n, input int d);
    int made;
    int len;
    int v;
    int step;
    int trend;
    bit noise;
    bit keep_open;
    made = 0;
    while (made < n) begin
      len       = $urandom_range(2, 60);
      noise     = ($urandom_range(0, 4) == 0);
      keep_open = ($urandom_range(0, 7) == 0);
      v         = int'($urandom_range(0, 65535)) - 32768;
      step      = d / 3 + 8;
      if (step > 30000) step = 30000;
      trend = $urandom_range(0, 1) ? 1 : -1;
      for (int k = 0; k < len && made < n; k++) begin
        if (noise) begin
          v = int'($urandom_range(0, 65535)) - 32768;
        end else if ($urandom_range(0, 15) != 0) begin
          // occasional repeat of the previous value exercises equal extremes
          if ($urandom_range(0, 4) == 0) trend = -trend;
          v = clamp_sample(v + trend * int'($urandom_range(0, step)));
        end
        queue_sample(v, (k == len - 1 && !keep_open) ||
                        (noise && $urandom_range(0, 9) == 0));
        made++;
      end
    end
  endfunction

  // wait until every request is taken and every event is back
  task automatic wait_idle();
    while (pending_samples.size() != 0 || samples_ch.valid || expected_events.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one delta register write, called right after a rising edge
  task automatic write_delta(input logic [DELTA_BITS-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_delta = d;
    delta_writes++;
  endtask

  // sample driver: bursts of requests with random gaps
  always @(posedge clk) begin : drive_samples
    sample_req_t req;
    if (rst) begin
      samples_ch.valid <= 1'b0;
    end else if (!samples_ch.valid || samples_ch.ready) begin
      if (burst_left == 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (burst_left > 0 && pending_samples.size() > 0) begin
        req = pending_samples.pop_front();
        samples_ch.valid       <= 1'b1;
        samples_ch.sample      <= req.smp;
        samples_ch.last_sample <= req.last;
        burst_left--;
      end else begin
        samples_ch.valid <= 1'b0;
      end
    end
  end

  // event monitor: check taken events, then predict from taken samples
  always @(posedge clk) begin : watch_events
    event_t got;
    event_t want;
    logic   nxt_ready;
    if (!rst) begin
      if (events_ch.valid && events_ch.ready) begin
        got.kind   = events_ch.event_kind;
        got.index  = events_ch.event_index;
        got.value  = events_ch.event_value;
        got.number = events_ch.event_number;
        if (got.kind == EVT_PEAK) peaks_seen++;
        else troughs_seen++;
        if (expected_events.size() == 0) begin
          $error("unexpected event: kind %0d index %0d value %0d number %0d",
                 got.kind, got.index, got.value, got.number);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          if (got.kind !== want.kind) begin
            $error("event_kind: expected %0d, got %0d", want.kind, got.kind);
            fail_count++;
          end
          if (got.index !== want.index) begin
            $error("event_index: expected %0d, got %0d", want.index, got.index);
            fail_count++;
          end
          if (got.value !== want.value) begin
            $error("event_value: expected %0d, got %0d", want.value, got.value);
            fail_count++;
          end
          if (got.number !== want.number) begin
            $error("event_number: expected %0d, got %0d", want.number, got.number);
            fail_count++;
          end
        end
      end
      if (samples_ch.valid && samples_ch.ready) begin
        predict_extremes(samples_ch.sample, samples_ch.last_sample);
        samples_taken++;
      end
    end
    // receiver stall pattern: always ready, coin flips, or a periodic pattern
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(32, 256);
      stall_per  = $urandom_range(2, 9);
      stall_low  = $urandom_range(1, stall_per - 1);
      stall_tick = 0;
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       nxt_ready = 1'b1;
      1:       nxt_ready = 1'($urandom_range(0, 1));
      default: nxt_ready = (stall_tick % stall_per) >= stall_low;
    endcase
    stall_tick++;
    events_ch.ready <= nxt_ready;
  end

  // stimulus sequence
  initial begin
    rst          <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    clear_tracker();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset delta: rise, hold on equal peak, peak, hold on equal trough, trough, extremes
    @(negedge clk);
    queue_sample(0, 1'b0);
    queue_sample(300, 1'b0);
    queue_sample(500, 1'b0);
    queue_sample(500, 1'b0);
    queue_sample(300, 1'b0);
    queue_sample(100, 1'b0);
    queue_sample(100, 1'b0);
    queue_sample(300, 1'b0);
    queue_sample(32767, 1'b0);
    queue_sample(-32768, 1'b0);
    queue_sample(32767, 1'b1);
    wait_idle();

    // zero delta: first sample turns falling at once
    write_delta(16'd0);
    @(negedge clk);
    queue_sample(-5, 1'b0);
    queue_sample(-5, 1'b0);
    queue_sample(-4, 1'b0);
    queue_sample(-4, 1'b0);
    queue_sample(-10, 1'b0);
    queue_sample(0, 1'b1);
    wait_idle();

    // full delta: comparisons over the whole sample range
    write_delta(16'hFFFF);
    @(negedge clk);
    queue_sample(-32768, 1'b0);
    queue_sample(32767, 1'b0);
    queue_sample(-32768, 1'b0);
    queue_sample(32767, 1'b0);
    queue_sample(0, 1'b1);
    wait_idle();

    // alternating window at zero delta: an event on almost every sample
    write_delta(16'd0);
    @(negedge clk);
    for (int k = 0; k < LONG_WINDOW; k++) begin
      if (k % 2 == 0) queue_sample(int'($urandom_range(0, 32767)), k == LONG_WINDOW - 1);
      else queue_sample(-1 - int'($urandom_range(0, 32767)), k == LONG_WINDOW - 1);
    end
    wait_idle();

    // random phases over a spread of delta settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      logic [DELTA_BITS-1:0] d;
      case (p)
        0:       d = DELTA_BITS'($urandom_range(0, 15));
        1:       d = DELTA_BITS'($urandom_range(16, 400));
        2:       d = DELTA_RESET;
        3:       d = DELTA_BITS'($urandom_range(400, 4000));
        4:       d = DELTA_BITS'($urandom_range(0, 65535));
        5:       d = 16'hFFFF;
        6:       d = DELTA_BITS'($urandom_range(4000, 30000));
        default: d = DELTA_BITS'($urandom_range(1, 100));
      endcase
      write_delta(d);
      @(negedge clk);
      fill_random_phase(PHASE_ITEMS, int'(d));
      wait_idle();
    end

    $display("run covered %0d samples and %0d events (%0d peaks, %0d troughs)",
             samples_taken, peaks_seen + troughs_seen, peaks_seen, troughs_seen);
    $display("with %0d delta writes, including zero, full scale and one alternating window",
             delta_writes);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/hptd_pkg.sv
src/hptd_ifs.sv
src/hptd_core.sv
src/hysteresis_peak_trough_detector.sv
sim/tb_hysteresis_peak_trough_detector.sv
